>>> rtl/etf_pkg.sv
// Shared constants, item types, command types and helper functions of the fractal pixel engine.
package etf_pkg;

  localparam int COORD_FRAC_BITS_DEF = 56;
  localparam int MAX_FRAME_DEF = 4096;
  localparam int ITER_BITS_DEF = 16;

  localparam int COORD_W = 64;
  localparam int WIDE_W = 128;
  localparam int PIXEL_W = 12;
  localparam int DIM_CFG_W = 13;
  localparam int MAXI_W = 16;
  localparam int TOTAL_W = 48;
  localparam int COLOUR_W = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int STEP_W = 7;

  // Mapping constants: 3.5 = 7 / 2, 2.5 = 5 / 2, with extra shifts for the halves.
  localparam int X_SPAN = 7;
  localparam int X_SPAN_W = 3;
  localparam int X_OFF = 5;
  localparam int X_OFF_W = 3;
  localparam int X_EXTRA = 31;
  localparam int Y_SCALE_EXTRA = 33;
  localparam int Y_OFF_EXTRA = 32;
  localparam int ESC_EXTRA = 2;

  localparam int COLOUR_LOG2 = 24;
  localparam int RED_DIV = 65025;
  localparam int GREEN_DIV = 255;

  // For x below 2^24, x / 255 equals (x * RECIP_255) >> RECIP_SHIFT.
  localparam int RECIP_W = 32;
  localparam logic [RECIP_W-1:0] RECIP_255 = 32'h0080_8081;
  localparam int RECIP_SHIFT = 31;

  localparam logic [CFG_INDEX_W-1:0] CFG_PAN_X = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PAN_Y = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ZOOM = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ITERATIONS = 3'd5;

  localparam logic [COORD_W-1:0] ZOOM_RESET = 64'h0000_0001_0000_0000;
  localparam logic [DIM_CFG_W-1:0] WIDTH_RESET = 13'd640;
  localparam logic [DIM_CFG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [MAXI_W-1:0] MAXI_RESET = 16'd256;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_x;
    logic [PIXEL_W-1:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
    logic [MAXI_W-1:0]   iter_count;
    logic [TOTAL_W-1:0]  running_total;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_PIXEL,
    OP_DIV_GO,
    OP_POST,
    OP_MAG,
    OP_MUL,
    OP_SUM,
    OP_UPDATE,
    OP_BLACK,
    OP_FINISH
  } dp_op_t;

  typedef enum logic [3:0] {
    SEL_CX_SCALE,
    SEL_CX_OFF,
    SEL_CY_SCALE,
    SEL_CY_OFF,
    SEL_STEP,
    SEL_TC_Q,
    SEL_RED,
    SEL_RED_SUB,
    SEL_GREEN,
    SEL_BLUE
  } div_sel_t;

  typedef struct packed {
    dp_op_t   op;
    div_sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic at_limit;
    logic escaped;
    logic out_free;
  } status_t;

  // Clamps a two's complement wide value to the signed 64-bit range.
  function automatic logic [COORD_W-1:0] sat64(input logic [WIDE_W-1:0] v);
    logic [COORD_W-1:0] r;
    if (v[WIDE_W-1:COORD_W-1] == '0 || v[WIDE_W-1:COORD_W-1] == '1) begin
      r = v[COORD_W-1:0];
    end else if (v[WIDE_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] mag64(input logic [COORD_W-1:0] v);
    return v[COORD_W-1] ? (~v + COORD_W'(1)) : v;
  endfunction

  function automatic logic [WIDE_W-1:0] sext64(input logic [COORD_W-1:0] v);
    return {{(WIDE_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

endpackage

>>> rtl/etf_div.sv
// Restoring divider, one quotient bit per cycle, numerator given top-aligned.
module etf_div #(
  parameter int DVS_W = 77
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [etf_pkg::WIDE_W-1:0]     num,
  input  logic [DVS_W-1:0]               dvs,
  input  logic [etf_pkg::STEP_W-1:0]     steps,
  output logic                           busy,
  output logic [etf_pkg::WIDE_W-1:0]     quo
);

  logic [etf_pkg::WIDE_W-1:0] shreg;
  logic [DVS_W-1:0]           rem;
  logic [DVS_W-1:0]           dvs_r;
  logic [etf_pkg::STEP_W-1:0] cnt;
  logic [DVS_W:0]             shifted;
  logic [DVS_W:0]             trial;
  logic                       take;

  always_comb begin
    shifted = {rem, shreg[etf_pkg::WIDE_W-1]};
    trial = shifted - {1'b0, dvs_r};
    take = !trial[DVS_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= steps;
    end else if (cnt != '0) begin
      cnt <= cnt - etf_pkg::STEP_W'(1);
    end
  end

  // The quotient bits enter at the bottom as the numerator leaves at the top.
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= num;
      rem <= '0;
      dvs_r <= dvs;
    end else if (cnt != '0) begin
      shreg <= {shreg[etf_pkg::WIDE_W-2:0], take};
      rem <= take ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign busy = (cnt != '0);
  assign quo = shreg;

endmodule

>>> rtl/etf_dp.sv
// Datapath: configuration registers, coordinate mapping, iteration, colour and result register.
module etf_dp #(
  parameter int COORD_FRAC_BITS = etf_pkg::COORD_FRAC_BITS_DEF,
  parameter int MAX_FRAME = etf_pkg::MAX_FRAME_DEF,
  parameter int ITER_BITS = etf_pkg::ITER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [etf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [etf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  etf_pkg::in_item_t                 in_data,
  input  etf_pkg::cmd_t                     cmd,
  output etf_pkg::status_t                  status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output etf_pkg::out_item_t                out_data
);

  localparam int W = etf_pkg::WIDE_W;
  localparam int CW = etf_pkg::COORD_W;
  localparam int HW = CW / 2;
  localparam int F = COORD_FRAC_BITS;
  localparam int DIM_W = $clog2(MAX_FRAME + 1);
  localparam int DVS_W = CW + DIM_W;
  localparam int N_W = (ITER_BITS < etf_pkg::MAXI_W) ? ITER_BITS : etf_pkg::MAXI_W;
  localparam int TC_W = etf_pkg::COLOUR_LOG2;
  localparam int QP_W = TC_W + etf_pkg::RECIP_W;
  localparam int PX7_W = etf_pkg::PIXEL_W + etf_pkg::X_SPAN_W;
  localparam logic [W-1:0] ESC_LIMIT = W'(1) << (2 * F + etf_pkg::ESC_EXTRA);
  localparam logic [etf_pkg::STEP_W-1:0] STEPS_CX_SCALE =
    etf_pkg::STEP_W'(PX7_W + F + etf_pkg::X_EXTRA);
  localparam logic [etf_pkg::STEP_W-1:0] STEPS_CX_OFF =
    etf_pkg::STEP_W'(etf_pkg::X_OFF_W + F + etf_pkg::X_EXTRA);
  localparam logic [etf_pkg::STEP_W-1:0] STEPS_CY_SCALE =
    etf_pkg::STEP_W'(etf_pkg::PIXEL_W + F + etf_pkg::Y_SCALE_EXTRA);
  localparam logic [etf_pkg::STEP_W-1:0] STEPS_CY_OFF =
    etf_pkg::STEP_W'(1 + F + etf_pkg::Y_OFF_EXTRA);
  localparam logic [etf_pkg::STEP_W-1:0] STEPS_STEP =
    etf_pkg::STEP_W'(1 + etf_pkg::COLOUR_LOG2);
  localparam logic [etf_pkg::STEP_W-1:0] STEPS_COLOUR = etf_pkg::STEP_W'(TC_W);

  // Configuration.
  logic [CW-1:0]                   pan_x;
  logic [CW-1:0]                   pan_y;
  logic [CW-1:0]                   zoom;
  logic [etf_pkg::DIM_CFG_W-1:0]   frame_width;
  logic [etf_pkg::DIM_CFG_W-1:0]   frame_height;
  logic [etf_pkg::MAXI_W-1:0]      max_iterations;
  logic [etf_pkg::TOTAL_W-1:0]     total;

  // Working registers.
  logic [etf_pkg::PIXEL_W-1:0] px;
  logic [etf_pkg::PIXEL_W-1:0] py;
  logic [W-1:0]  acc;
  logic [CW-1:0] cx;
  logic [CW-1:0] cy;
  logic [CW-1:0] zx;
  logic [CW-1:0] zy;
  logic [CW-1:0] ax;
  logic [CW-1:0] ay;
  logic          neg;
  logic [CW-1:0] xx_ll, xx_lh, xx_hh;
  logic [CW-1:0] yy_ll, yy_lh, yy_hh;
  logic [CW-1:0] xy_ll, xy_lh, xy_hl, xy_hh;
  logic [W-1:0]  sx;
  logic [W-1:0]  sy;
  logic [W-1:0]  pxy;
  logic [N_W-1:0] n;
  logic [TC_W-1:0] tc;
  logic [TC_W-1:0] q255;
  logic [etf_pkg::COLOUR_W-1:0] red;
  logic [etf_pkg::COLOUR_W-1:0] green;
  logic [etf_pkg::COLOUR_W-1:0] blue;

  // Derived values.
  logic [CW-1:0]    zq;
  logic [DIM_W-1:0] wdim;
  logic [DIM_W-1:0] hdim;
  logic [DIM_W-1:0] dim_sel;
  logic [N_W-1:0]   maxi;
  logic [PX7_W-1:0] px7;
  logic [W-1:0]     div_num;
  logic [DVS_W-1:0] div_dvs;
  logic [etf_pkg::STEP_W-1:0] div_steps;
  logic             div_busy;
  logic [W-1:0]     quo;
  logic [W-1:0]     diff;
  logic [W-1:0]     pcross;
  logic [W-1:0]     pcross_s;
  logic [CW-1:0]    nx;
  logic [CW-1:0]    ny;
  logic             escaped;
  logic [N_W+TC_W:0] tc_prod;
  logic [TC_W-1:0]  d255_in;
  logic [QP_W-1:0]  d255_prod;
  logic [TC_W-1:0]  red_part;
  logic [TC_W-1:0]  green_rest;

  function automatic logic [DIM_W-1:0] frame_dim(input logic [etf_pkg::DIM_CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > 32'(MAX_FRAME)) begin
      r = DIM_W'(MAX_FRAME);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  always_comb begin
    zq = (zoom == '0) ? CW'(1) : zoom;
    wdim = frame_dim(frame_width);
    hdim = frame_dim(frame_height);
    maxi = max_iterations[N_W-1:0];
    px7 = (PX7_W'(px) << etf_pkg::X_SPAN_W) - PX7_W'(px);
    dim_sel = (cmd.sel == etf_pkg::SEL_CX_SCALE) ? wdim : hdim;
  end

  always_comb begin
    case (cmd.sel)
      etf_pkg::SEL_CX_SCALE: begin
        div_num = W'(px7) << (W - PX7_W);
        div_dvs = DVS_W'(zq) * DVS_W'(dim_sel);
        div_steps = STEPS_CX_SCALE;
      end
      etf_pkg::SEL_CX_OFF: begin
        div_num = W'(etf_pkg::X_OFF) << (W - etf_pkg::X_OFF_W);
        div_dvs = DVS_W'(zq);
        div_steps = STEPS_CX_OFF;
      end
      etf_pkg::SEL_CY_SCALE: begin
        div_num = W'(py) << (W - etf_pkg::PIXEL_W);
        div_dvs = DVS_W'(zq) * DVS_W'(dim_sel);
        div_steps = STEPS_CY_SCALE;
      end
      etf_pkg::SEL_CY_OFF: begin
        div_num = W'(1) << (W - 1);
        div_dvs = DVS_W'(zq);
        div_steps = STEPS_CY_OFF;
      end
      etf_pkg::SEL_STEP: begin
        div_num = W'(1) << (W - 1);
        div_dvs = DVS_W'(maxi);
        div_steps = STEPS_STEP;
      end
      default: begin
        div_num = '0;
        div_dvs = DVS_W'(1);
        div_steps = STEPS_COLOUR;
      end
    endcase
  end

  etf_div #(
    .DVS_W(DVS_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.op == etf_pkg::OP_DIV_GO),
    .num  (div_num),
    .dvs  (div_dvs),
    .steps(div_steps),
    .busy (div_busy),
    .quo  (quo)
  );

  // Iteration update: the escape test sees the squares of the current point.
  always_comb begin
    escaped = (sx + sy) >= ESC_LIMIT;
    diff = sx - sy;
    nx = etf_pkg::sat64(W'($signed(diff) >>> F) + etf_pkg::sext64(cx));
    pcross = pxy << 1;
    pcross_s = neg ? (W'(0) - pcross) : pcross;
    ny = etf_pkg::sat64(W'($signed(pcross_s) >>> F) + etf_pkg::sext64(cy));
    tc_prod = (N_W+TC_W+1)'(quo[TC_W:0]) * (N_W+TC_W+1)'(n);
    // Red is the quotient by 255 taken twice, since 65025 is 255 squared.
    d255_in = (cmd.sel == etf_pkg::SEL_RED) ? q255 : tc;
    d255_prod = QP_W'(d255_in) * QP_W'(etf_pkg::RECIP_255);
    red_part = TC_W'(red) * TC_W'(etf_pkg::RED_DIV);
    green_rest = tc - TC_W'(green) * TC_W'(etf_pkg::GREEN_DIV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pan_x <= '0;
      pan_y <= '0;
      zoom <= etf_pkg::ZOOM_RESET;
      frame_width <= etf_pkg::WIDTH_RESET;
      frame_height <= etf_pkg::HEIGHT_RESET;
      max_iterations <= etf_pkg::MAXI_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        etf_pkg::CFG_PAN_X: pan_x <= cfg_data;
        etf_pkg::CFG_PAN_Y: pan_y <= cfg_data;
        etf_pkg::CFG_ZOOM: zoom <= cfg_data;
        etf_pkg::CFG_FRAME_WIDTH: frame_width <= cfg_data[etf_pkg::DIM_CFG_W-1:0];
        etf_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data[etf_pkg::DIM_CFG_W-1:0];
        etf_pkg::CFG_MAX_ITERATIONS: max_iterations <= cfg_data[etf_pkg::MAXI_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      out_valid <= 1'b0;
    end else if (cmd.op == etf_pkg::OP_FINISH) begin
      total <= total + etf_pkg::TOTAL_W'(n);
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      etf_pkg::OP_LOAD_PIXEL: begin
        px <= in_data.pixel_x;
        py <= in_data.pixel_y;
      end
      etf_pkg::OP_POST: begin
        case (cmd.sel)
          etf_pkg::SEL_CX_SCALE: acc <= quo;
          etf_pkg::SEL_CX_OFF: cx <= etf_pkg::sat64(acc - quo + etf_pkg::sext64(pan_x));
          etf_pkg::SEL_CY_SCALE: acc <= quo;
          etf_pkg::SEL_CY_OFF: begin
            cy <= etf_pkg::sat64(acc - quo + etf_pkg::sext64(pan_y));
            zx <= '0;
            zy <= '0;
            n <= '0;
          end
          etf_pkg::SEL_STEP: tc <= tc_prod[TC_W-1:0];
          etf_pkg::SEL_TC_Q: q255 <= d255_prod[etf_pkg::RECIP_SHIFT +: TC_W];
          etf_pkg::SEL_RED: red <= d255_prod[etf_pkg::RECIP_SHIFT +: etf_pkg::COLOUR_W];
          etf_pkg::SEL_RED_SUB: tc <= tc - red_part;
          etf_pkg::SEL_GREEN: green <= d255_prod[etf_pkg::RECIP_SHIFT +: etf_pkg::COLOUR_W];
          etf_pkg::SEL_BLUE: blue <= green_rest[etf_pkg::COLOUR_W-1:0];
          default: begin
          end
        endcase
      end
      etf_pkg::OP_MAG: begin
        ax <= etf_pkg::mag64(zx);
        ay <= etf_pkg::mag64(zy);
        neg <= zx[CW-1] ^ zy[CW-1];
      end
      etf_pkg::OP_MUL: begin
        xx_ll <= ax[HW-1:0] * ax[HW-1:0];
        xx_lh <= ax[HW-1:0] * ax[CW-1:HW];
        xx_hh <= ax[CW-1:HW] * ax[CW-1:HW];
        yy_ll <= ay[HW-1:0] * ay[HW-1:0];
        yy_lh <= ay[HW-1:0] * ay[CW-1:HW];
        yy_hh <= ay[CW-1:HW] * ay[CW-1:HW];
        xy_ll <= ax[HW-1:0] * ay[HW-1:0];
        xy_lh <= ax[HW-1:0] * ay[CW-1:HW];
        xy_hl <= ax[CW-1:HW] * ay[HW-1:0];
        xy_hh <= ax[CW-1:HW] * ay[CW-1:HW];
      end
      etf_pkg::OP_SUM: begin
        // The cross term of a square appears twice, hence the shift by one more place.
        sx <= (W'(xx_hh) << CW) + (W'(xx_lh) << (HW + 1)) + W'(xx_ll);
        sy <= (W'(yy_hh) << CW) + (W'(yy_lh) << (HW + 1)) + W'(yy_ll);
        pxy <= (W'(xy_hh) << CW) + (W'(xy_lh) << HW) + (W'(xy_hl) << HW) + W'(xy_ll);
      end
      etf_pkg::OP_UPDATE: begin
        if (!escaped) begin
          zx <= nx;
          zy <= ny;
          n <= n + N_W'(1);
        end
      end
      etf_pkg::OP_BLACK: begin
        red <= '0;
        green <= '0;
        blue <= '0;
      end
      etf_pkg::OP_FINISH: begin
        out_data.red <= red;
        out_data.green <= green;
        out_data.blue <= blue;
        out_data.iter_count <= etf_pkg::MAXI_W'(n);
        out_data.running_total <= total + etf_pkg::TOTAL_W'(n);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status.div_busy = div_busy;
    status.at_limit = (n >= maxi);
    status.escaped = escaped;
    status.out_free = !out_valid || out_ready;
  end

endmodule

>>> rtl/etf_ctrl.sv
// Controller: sequences mapping divisions, the escape loop, colour and result hand-over.
module etf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  etf_pkg::status_t  status,
  output etf_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_POST,
    S_MAG,
    S_MUL,
    S_SUM,
    S_UPD,
    S_COL_CHK,
    S_BLACK,
    S_FINISH
  } state_t;

  state_t state;
  etf_pkg::div_sel_t sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel <= etf_pkg::SEL_CX_SCALE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DIV_GO;
            sel <= etf_pkg::SEL_CX_SCALE;
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (!status.div_busy) begin
            state <= S_POST;
          end
        end
        S_POST: begin
          case (sel)
            etf_pkg::SEL_CX_SCALE: begin
              sel <= etf_pkg::SEL_CX_OFF;
              state <= S_DIV_GO;
            end
            etf_pkg::SEL_CX_OFF: begin
              sel <= etf_pkg::SEL_CY_SCALE;
              state <= S_DIV_GO;
            end
            etf_pkg::SEL_CY_SCALE: begin
              sel <= etf_pkg::SEL_CY_OFF;
              state <= S_DIV_GO;
            end
            etf_pkg::SEL_CY_OFF: state <= S_MAG;
            // The colour steps after the division run one after another in this state.
            etf_pkg::SEL_STEP: begin
              sel <= etf_pkg::SEL_TC_Q;
              state <= S_POST;
            end
            etf_pkg::SEL_TC_Q: begin
              sel <= etf_pkg::SEL_RED;
              state <= S_POST;
            end
            etf_pkg::SEL_RED: begin
              sel <= etf_pkg::SEL_RED_SUB;
              state <= S_POST;
            end
            etf_pkg::SEL_RED_SUB: begin
              sel <= etf_pkg::SEL_GREEN;
              state <= S_POST;
            end
            etf_pkg::SEL_GREEN: begin
              sel <= etf_pkg::SEL_BLUE;
              state <= S_POST;
            end
            default: state <= S_FINISH;
          endcase
        end
        S_MAG: state <= status.at_limit ? S_COL_CHK : S_MUL;
        S_MUL: state <= S_SUM;
        S_SUM: state <= S_UPD;
        S_UPD: state <= status.escaped ? S_COL_CHK : S_MAG;
        S_COL_CHK: begin
          if (status.at_limit) begin
            state <= S_BLACK;
          end else begin
            sel <= etf_pkg::SEL_STEP;
            state <= S_DIV_GO;
          end
        end
        S_BLACK: state <= S_FINISH;
        S_FINISH: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.sel = sel;
    case (state)
      S_IDLE: cmd.op = in_valid ? etf_pkg::OP_LOAD_PIXEL : etf_pkg::OP_NONE;
      S_DIV_GO: cmd.op = etf_pkg::OP_DIV_GO;
      S_POST: cmd.op = etf_pkg::OP_POST;
      S_MAG: cmd.op = etf_pkg::OP_MAG;
      S_MUL: cmd.op = etf_pkg::OP_MUL;
      S_SUM: cmd.op = etf_pkg::OP_SUM;
      S_UPD: cmd.op = etf_pkg::OP_UPDATE;
      S_BLACK: cmd.op = etf_pkg::OP_BLACK;
      S_FINISH: cmd.op = status.out_free ? etf_pkg::OP_FINISH : etf_pkg::OP_NONE;
      default: cmd.op = etf_pkg::OP_NONE;
    endcase
  end

  assign in_ready = (state == S_IDLE);

endmodule

>>> rtl/escape_time_fractal_pixel.sv
// Escape-time fractal pixel engine: one pixel item in, one colour item out.
// Sequence: coordinate mapping (four bit-serial divisions on the shared divider), then the
// escape loop (magnitude, multiply, sum and update states per iteration), then colour (one
// division and five short steps), or a black colour at the limit when the point stays inside.
// One item at a time; the next item is taken the cycle after a result enters the output register.
// Synchronous reset restores the configuration defaults, clears the total and empties the block.
module escape_time_fractal_pixel #(
  parameter int COORD_FRAC_BITS = etf_pkg::COORD_FRAC_BITS_DEF,
  parameter int MAX_FRAME = etf_pkg::MAX_FRAME_DEF,
  parameter int ITER_BITS = etf_pkg::ITER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [etf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [etf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  etf_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output etf_pkg::out_item_t               out_data
);

  etf_pkg::cmd_t    cmd;
  etf_pkg::status_t status;

  etf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  etf_dp #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .MAX_FRAME      (MAX_FRAME),
    .ITER_BITS      (ITER_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

`ifndef NO_ASSERTIONS
  // Once an item is taken the block is busy with it.
  assert property (@(posedge clk) disable iff (rst) in_valid && in_ready |=> !in_ready)
    else $error("item accepted but block still ready");

  // A point that escapes at once yields a zero colour.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.iter_count == '0 |->
      out_data.red == '0 && out_data.green == '0 && out_data.blue == '0)
    else $error("zero iteration count with non-black colour");

  // The result register is only loaded when it is free.
  assert property (@(posedge clk) disable iff (rst)
    cmd.op == etf_pkg::OP_FINISH |-> status.out_free)
    else $error("result loaded over an unread item");
`endif

endmodule

>>> verif/tb.sv
// Self-checking testbench for the escape-time fractal pixel engine.
`timescale 1ns / 100ps

module tb;

  localparam int FB = etf_pkg::COORD_FRAC_BITS_DEF;

  typedef struct {
    logic [63:0] pan_x;
    logic [63:0] pan_y;
    logic [63:0] zoom;
    logic [12:0] frame_w;
    logic [12:0] frame_h;
    logic [15:0] iter_limit;
  } view_t;

  class pixel_scoreboard;
    view_t view;
    logic [etf_pkg::TOTAL_W-1:0] iter_total;
    etf_pkg::out_item_t pending[$];
    int errors;

    function new();
      view.pan_x = '0;
      view.pan_y = '0;
      view.zoom = etf_pkg::ZOOM_RESET;
      view.frame_w = etf_pkg::WIDTH_RESET;
      view.frame_h = etf_pkg::HEIGHT_RESET;
      view.iter_limit = etf_pkg::MAXI_RESET;
      iter_total = '0;
      errors = 0;
    endfunction

    function logic [127:0] clamp_dim(logic [12:0] d);
      if (d == 0) return 128'd1;
      if (d > etf_pkg::MAX_FRAME_DEF) return 128'(etf_pkg::MAX_FRAME_DEF);
      return 128'(d);
    endfunction

    // Clamp a two's complement 128-bit value into the signed 64-bit range.
    function logic [63:0] clamp64(logic [127:0] v);
      if (v[127:63] == '0 || v[127:63] == '1) return v[63:0];
      return v[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    endfunction

    function logic [127:0] widen(logic [63:0] v);
      return {{64{v[63]}}, v};
    endfunction

    function logic [63:0] absval(logic [63:0] v);
      return v[63] ? -v : v;
    endfunction

    function etf_pkg::out_item_t compute_pixel(etf_pkg::in_item_t it);
      logic [127:0] zq, t, sx, sy, p, d, sh, lim;
      logic [63:0] cx, cy, zx, zy, ax, ay, nx, tc, rr, gg, bb;
      int unsigned n, lim_n;
      etf_pkg::out_item_t o;
      zq = (view.zoom == 0) ? 128'd1 : 128'(view.zoom);
      t = ((128'(it.pixel_x) * 7) << (FB + 31)) / (zq * clamp_dim(view.frame_w));
      t = t - ((128'd5 << (FB + 31)) / zq);
      cx = clamp64(t + widen(view.pan_x));
      t = (128'(it.pixel_y) << (FB + 33)) / (zq * clamp_dim(view.frame_h));
      t = t - ((128'd1 << (FB + 32)) / zq);
      cy = clamp64(t + widen(view.pan_y));
      lim = 128'd1 << (2 * FB + 2);
      lim_n = view.iter_limit;
      zx = '0;
      zy = '0;
      n = 0;
      while (n < lim_n) begin
        ax = absval(zx);
        ay = absval(zy);
        sx = 128'(ax) * 128'(ax);
        sy = 128'(ay) * 128'(ay);
        if (sx + sy >= lim) break;
        d = sx - sy;
        sh = $signed(d) >>> FB;
        nx = clamp64(sh + widen(cx));
        p = (128'(ax) * 128'(ay)) << 1;
        if (zx[63] ^ zy[63]) p = -p;
        sh = $signed(p) >>> FB;
        zy = clamp64(sh + widen(cy));
        zx = nx;
        n++;
      end
      rr = 0;
      gg = 0;
      bb = 0;
      if (n < lim_n) begin
        tc = 64'(n) * (64'd16777216 / 64'(lim_n));
        rr = (tc / etf_pkg::RED_DIV) & 255;
        tc = tc - rr * etf_pkg::RED_DIV;
        gg = (tc / etf_pkg::GREEN_DIV) & 255;
        tc = tc - gg * etf_pkg::GREEN_DIV;
        bb = tc & 255;
      end
      iter_total = iter_total + etf_pkg::TOTAL_W'(n);
      o.red = rr[7:0];
      o.green = gg[7:0];
      o.blue = bb[7:0];
      o.iter_count = n[15:0];
      o.running_total = iter_total;
      return o;
    endfunction

    function void note_pixel(etf_pkg::in_item_t it);
      pending.push_back(compute_pixel(it));
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    task check_colour(etf_pkg::out_item_t got);
      etf_pkg::out_item_t want;
      if (pending.size() == 0) begin
        report("result item with nothing expected");
        return;
      end
      want = pending.pop_front();
      if (got.red != want.red)
        report($sformatf("red %0d, expected %0d", got.red, want.red));
      if (got.green != want.green)
        report($sformatf("green %0d, expected %0d", got.green, want.green));
      if (got.blue != want.blue)
        report($sformatf("blue %0d, expected %0d", got.blue, want.blue));
      if (got.iter_count != want.iter_count)
        report($sformatf("iter_count %0d, expected %0d", got.iter_count, want.iter_count));
      if (got.running_total != want.running_total)
        report($sformatf("running_total %0d, expected %0d",
                         got.running_total, want.running_total));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [etf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [etf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  etf_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  etf_pkg::out_item_t out_data;

  pixel_scoreboard board = new();
  int burst_left = 0;
  int results_seen = 0;

  escape_time_fractal_pixel i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random stall pattern, with one long hold-off to back the block up.
  initial begin
    int mode_left;
    bit steady;
    bit held;
    mode_left = 0;
    steady = 1'b0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 150) begin
        held = 1'b1;
        out_ready = 1'b0;
        repeat (3000) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 400);
        steady = ($urandom_range(0, 2) == 0);
      end
      mode_left--;
      out_ready = steady ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_colour(out_data);
      results_seen++;
    end
  end

  task automatic write_reg(logic [etf_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      etf_pkg::CFG_PAN_X: board.view.pan_x = val;
      etf_pkg::CFG_PAN_Y: board.view.pan_y = val;
      etf_pkg::CFG_ZOOM: board.view.zoom = val;
      etf_pkg::CFG_FRAME_WIDTH: board.view.frame_w = val[12:0];
      etf_pkg::CFG_FRAME_HEIGHT: board.view.frame_h = val[12:0];
      etf_pkg::CFG_MAX_ITERATIONS: board.view.iter_limit = val[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_view(view_t v);
    write_reg(etf_pkg::CFG_PAN_X, v.pan_x);
    write_reg(etf_pkg::CFG_PAN_Y, v.pan_y);
    write_reg(etf_pkg::CFG_ZOOM, v.zoom);
    write_reg(etf_pkg::CFG_FRAME_WIDTH, 64'(v.frame_w));
    write_reg(etf_pkg::CFG_FRAME_HEIGHT, 64'(v.frame_h));
    write_reg(etf_pkg::CFG_MAX_ITERATIONS, 64'(v.iter_limit));
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_pixel(logic [11:0] px, logic [11:0] py);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
    in_valid = 1'b1;
    in_data.pixel_x = px;
    in_data.pixel_y = py;
    do @(posedge clk); while (!in_ready);
    board.note_pixel(in_data);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic logic [11:0] pick_coord(logic [12:0] dim);
    if (dim == 0 || $urandom_range(0, 4) == 0) return 12'($urandom);
    return 12'($urandom_range(0, (dim > 4096 ? 4096 : dim) - 1));
  endfunction

  task automatic run_random(int count);
    repeat (count)
      send_pixel(pick_coord(board.view.frame_w), pick_coord(board.view.frame_h));
  endtask

  initial begin
    view_t v;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Default view: corners, frame edge and points just beyond the frame.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd0, 12'hFFF);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'd639, 12'd479);
    send_pixel(12'd640, 12'd480);
    send_pixel(12'd320, 12'd240);
    send_pixel(12'd160, 12'd240);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    drain();

    // Zero zoom, zero frame size, zero iteration limit, most negative pan.
    v.pan_x = 64'h8000_0000_0000_0000;
    v.pan_y = 64'h8000_0000_0000_0000;
    v.zoom = 64'd0;
    v.frame_w = 13'd0;
    v.frame_h = 13'd0;
    v.iter_limit = 16'd0;
    apply_view(v);
    run_random(6);
    drain();

    // Smallest zoom step with saturating coordinates, oversize frame, largest limit.
    v.pan_x = 64'h7FFF_FFFF_FFFF_FFFF;
    v.pan_y = 64'h7FFF_FFFF_FFFF_FFFF;
    v.zoom = 64'd1;
    v.frame_w = 13'h1FFF;
    v.frame_h = 13'd4096;
    v.iter_limit = 16'hFFFF;
    apply_view(v);
    run_random(6);
    drain();

    // Deepest zoom, one-pixel frame, centre moved out so points escape quickly.
    v.pan_x = 64'd1 << 58;
    v.pan_y = 64'd0;
    v.zoom = 64'hFFFF_FFFF_FFFF_FFFF;
    v.frame_w = 13'd1;
    v.frame_h = 13'd1;
    v.iter_limit = 16'hFFFF;
    apply_view(v);
    run_random(6);
    drain();

    v.pan_x = 64'd0;
    v.zoom = etf_pkg::ZOOM_RESET;
    v.frame_w = 13'd4096;
    v.frame_h = 13'd4096;
    v.iter_limit = 16'd1;
    apply_view(v);
    run_random(6);
    drain();

    repeat (10) begin
      v.pan_x = 64'($signed({$urandom, $urandom}) >>> $urandom_range(6, 12));
      v.pan_y = 64'($signed({$urandom, $urandom}) >>> $urandom_range(6, 12));
      v.zoom = (64'd1 << $urandom_range(30, 38)) + 64'($urandom);
      v.frame_w = ($urandom_range(0, 5) == 0) ? 13'($urandom) : 13'($urandom_range(1, 4096));
      v.frame_h = ($urandom_range(0, 5) == 0) ? 13'($urandom) : 13'($urandom_range(1, 4096));
      v.iter_limit = 16'($urandom_range(1, 48));
      apply_view(v);
      run_random(100);
      drain();
    end

    repeat (200) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> escape_time_fractal_pixel.f
rtl/etf_pkg.sv
rtl/etf_div.sv
rtl/etf_dp.sv
rtl/etf_ctrl.sv
rtl/escape_time_fractal_pixel.sv
verif/tb.sv
